// ----- hdl/tcm_pkg.sv -----
`default_nettype none

package tcm_pkg;

	// Screen size limits and tab stop spacing
	localparam logic [8:0] MAX_COLS  = 9'd256;
	localparam logic [8:0] MAX_ROWS  = 9'd256;
	localparam int         TAB_SHIFT = 3;

	// Configuration register indexes
	localparam int         CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

	localparam logic [8:0] RESET_COLUMNS = 9'd80;
	localparam logic [8:0] RESET_ROWS    = 9'd24;

	typedef enum logic [4:0] {
		OP_UP         = 5'd0,
		OP_DOWN       = 5'd1,
		OP_LEFT       = 5'd2,
		OP_RIGHT      = 5'd3,
		OP_INDEX      = 5'd4,
		OP_REVINDEX   = 5'd5,
		OP_MOVETO     = 5'd6,
		OP_TAB        = 5'd7,
		OP_BACKTAB    = 5'd8,
		OP_BS         = 5'd9,
		OP_REGION     = 5'd10,
		OP_SAVE       = 5'd11,
		OP_RESTORE    = 5'd12,
		OP_PRINT      = 5'd13,
		OP_SCROLLUP   = 5'd14,
		OP_SCROLLDOWN = 5'd15,
		OP_SCREEN     = 5'd16
	} opcode_t;

	typedef struct packed {
		logic [4:0]  opcode;
		logic [11:0] count;
		logic [11:0] arg_col;
		logic [11:0] arg_row;
		logic [11:0] arg_bottom;
		logic        char_wide;
	} cmd_t;

	typedef struct packed {
		logic [8:0] cur_col;
		logic [7:0] cur_row;
		logic [8:0] saved_col;
		logic [7:0] saved_row;
		logic [7:0] region_top;
		logic [8:0] region_bottom;
		logic       alt_screen;
	} state_t;

	typedef struct packed {
		logic [8:0] cursor_col;
		logic [7:0] cursor_row;
		logic [7:0] margin_top;
		logic [8:0] margin_bottom;
		logic [8:0] scroll_up_lines;
		logic [8:0] scroll_down_lines;
		logic       to_scrollback;
		logic       write_valid;
		logic [7:0] write_col;
		logic [7:0] write_row;
		logic       write_wide;
	} res_t;

	// Saturate a raw size register to 1..max
	function automatic logic [8:0] eff_dim(input logic [8:0] v, input logic [8:0] max);
		logic [8:0] r;
		r = v;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (v > max) begin
			r = max;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tcm_exec.sv -----
`default_nettype none

module tcm_exec (
	input  tcm_pkg::cmd_t   cmd,
	input  tcm_pkg::state_t st,
	input  logic [8:0]      w,
	input  logic [8:0]      h,
	output tcm_pkg::state_t nst,
	output tcm_pkg::res_t   res
);
	import tcm_pkg::*;

	typedef logic signed [17:0] sint_t;

	typedef struct packed {
		sint_t row;
		sint_t push;
	} mv_t;

	function automatic sint_t z8(input logic [7:0] v);
		return sint_t'({10'd0, v});
	endfunction

	function automatic sint_t z9(input logic [8:0] v);
		return sint_t'({9'd0, v});
	endfunction

	function automatic sint_t z12(input logic [11:0] v);
		return sint_t'({6'd0, v});
	endfunction

	function automatic sint_t clampi(input sint_t v, input sint_t lo, input sint_t hi);
		sint_t r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// Stop at the top margin when starting at or below it, else at row 0
	function automatic mv_t move_up(input sint_t r, input sint_t k, input sint_t t);
		mv_t   m;
		sint_t nx;
		nx = r - k;
		m.row = nx;
		m.push = '0;
		if (r >= t) begin
			if (nx < t) begin
				m.row = t;
				m.push = t - nx;
			end
		end else if (nx < 0) begin
			m.row = '0;
		end
		return m;
	endfunction

	// Stop at the bottom margin when starting above it, else at the last row
	function automatic mv_t move_down(input sint_t r, input sint_t k, input sint_t b,
			input sint_t hh);
		mv_t   m;
		sint_t nx;
		nx = r + k;
		m.row = nx;
		m.push = '0;
		if (r < b) begin
			if (nx >= b) begin
				m.row = b - 1;
				m.push = nx - (b - 1);
			end
		end else if (nx >= hh) begin
			m.row = hh - 1;
		end
		return m;
	endfunction

	sint_t col, row, top, bot, wi, hi, n, up, down, wc, wr, cw;
	mv_t   mv;
	logic  wv, ww;

	always_comb begin
		col  = z9(st.cur_col);
		row  = z8(st.cur_row);
		top  = z8(st.region_top);
		bot  = z9(st.region_bottom);
		wi   = z9(w);
		hi   = z9(h);
		n    = z12(cmd.count);
		up   = '0;
		down = '0;
		wc   = '0;
		wr   = '0;
		wv   = 1'b0;
		ww   = 1'b0;
		cw   = sint_t'(1);
		mv   = '0;
		nst  = st;
		case (cmd.opcode)
			OP_UP: begin
				if (n > 0) begin
					mv = move_up(row, n, top);
					row = mv.row;
				end
			end
			OP_DOWN: begin
				if (n > 0) begin
					mv = move_down(row, n, bot, hi);
					row = mv.row;
				end
			end
			OP_LEFT: begin
				if (n > 0) col = clampi(col - n, 0, wi);
			end
			OP_RIGHT: begin
				if (n > 0) col = clampi(col + n, 0, wi - 1);
			end
			OP_INDEX: begin
				if (n > 0) begin
					mv = move_down(row, n, bot, hi);
					if (row < bot) up = clampi(mv.push, 0, bot - top);
					row = mv.row;
				end
			end
			OP_REVINDEX: begin
				if (n > 0) begin
					mv = move_up(row, n, top);
					if (row >= top) down = clampi(mv.push, 0, bot - top);
					row = mv.row;
				end
			end
			OP_MOVETO: begin
				col = clampi(z12(cmd.arg_col), 0, wi - 1);
				row = clampi(z12(cmd.arg_row), 0, hi - 1);
			end
			OP_TAB: begin
				if (n > 0 && col < wi - 1) begin
					col = clampi(((col >>> TAB_SHIFT) + n) <<< TAB_SHIFT, 0, wi - 1);
				end
			end
			OP_BACKTAB: begin
				if (n > 0 && col > 0) begin
					col = clampi((((col - 1) >>> TAB_SHIFT) - n + 1) <<< TAB_SHIFT, 0, wi);
				end
			end
			OP_BS: begin
				if (col > 0) col = col - 1;
			end
			OP_REGION: begin
				if (z12(cmd.arg_bottom) >= z12(cmd.arg_row)) begin
					top = clampi(z12(cmd.arg_row), 0, hi - 1);
					bot = clampi(z12(cmd.arg_bottom), 0, hi);
					col = '0;
					row = '0;
				end
			end
			OP_SAVE: begin
				nst.saved_col = st.cur_col;
				nst.saved_row = st.cur_row;
			end
			OP_RESTORE: begin
				col = clampi(z9(st.saved_col), 0, wi - 1);
				row = clampi(z8(st.saved_row), 0, hi - 1);
			end
			OP_PRINT: begin
				if (cmd.char_wide && wi >= 2) cw = sint_t'(2);
				// Wrap: index one line, then start at column 0
				if (col + cw > wi) begin
					mv = move_down(row, sint_t'(1), bot, hi);
					if (row < bot) up = clampi(mv.push, 0, bot - top);
					row = mv.row;
					col = '0;
				end
				wv  = 1'b1;
				wc  = col;
				wr  = row;
				ww  = (cw == 2);
				col = col + cw;
			end
			OP_SCROLLUP: begin
				if (n > 0) begin
					up = clampi(n, 0, bot - top);
					if (row >= top && row < bot) begin
						col = clampi(col, 0, wi - 1);
						row = clampi(row - clampi(n, 0, row - top), 0, hi - 1);
					end
				end
			end
			OP_SCROLLDOWN: begin
				if (n > 0) begin
					down = clampi(n, 0, bot - top);
					if (row >= top && row < bot) begin
						col = clampi(col, 0, wi - 1);
						row = clampi(row + clampi(n, 0, bot - 1 - row), 0, hi - 1);
					end
				end
			end
			OP_SCREEN: begin
				nst.alt_screen = cmd.arg_col[0];
			end
			default: begin
			end
		endcase

		nst.cur_col       = col[8:0];
		nst.cur_row       = row[7:0];
		nst.region_top    = top[7:0];
		nst.region_bottom = bot[8:0];

		res.cursor_col        = col[8:0];
		res.cursor_row        = row[7:0];
		res.margin_top        = top[7:0];
		res.margin_bottom     = bot[8:0];
		res.scroll_up_lines   = up[8:0];
		res.scroll_down_lines = down[8:0];
		res.to_scrollback     = (up > 0) && (top == 0) && !nst.alt_screen;
		res.write_valid       = wv;
		res.write_col         = wc[7:0];
		res.write_row         = wr[7:0];
		res.write_wide        = ww;
	end

endmodule

`default_nettype wire

// ----- hdl/terminal_cursor_margin_controller_top.sv -----
// Each command is held in the command register; its result is then registered in the
// result register that drives m_tvalid. Throughput: one command per cycle unless
// m_tready stalls; the command and result registers refill in the cycle they drain.
// Reset (arst_n low, asynchronous): cursor, saved cursor and top margin go to zero,
// columns to 80, rows to 24, bottom margin to 24, main screen; both stages empty.
`default_nettype none

module terminal_cursor_margin_controller_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Command stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, lowest bit up: opcode[4:0], count[16:5], arg_col[28:17],
	// arg_row[40:29], arg_bottom[52:41], char_wide[53], zero[55:54]
	input  wire logic [55:0] s_tdata,
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata, lowest bit up: cursor_col[8:0], cursor_row[16:9], margin_top[24:17],
	// margin_bottom[33:25], scroll_up_lines[42:34], scroll_down_lines[51:43],
	// to_scrollback[52], write_valid[53], write_col[61:54], write_row[69:62],
	// write_wide[70], zero[71]
	output logic [71:0]      m_tdata,
	// Configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [8:0]  cfg_data
);
	import tcm_pkg::*;

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic       valid_s2;
	res_t       res_s2;
	state_t     st_q;
	logic [8:0] columns_q;
	logic [8:0] rows_q;

	logic       w_eff_ok;
	logic [8:0] w_eff, h_eff;
	logic [8:0] cfg_dim;
	logic       s_xfer, advance, cfg_xfer;
	state_t     st_next;
	res_t       res_next;

	// Size registers are used saturated to 1..max
	assign w_eff   = eff_dim(columns_q, MAX_COLS);
	assign h_eff   = eff_dim(rows_q, MAX_ROWS);
	assign cfg_dim = eff_dim(cfg_data, (cfg_index == REG_COLUMNS) ? MAX_COLS : MAX_ROWS);

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;

	// Move the command stage forward whenever the result register is free or draining
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign s_xfer   = s_tvalid & s_tready;

	tcm_exec u_exec (
		.cmd (cmd_s1),
		.st  (st_q),
		.w   (w_eff),
		.h   (h_eff),
		.nst (st_next),
		.res (res_next)
	);

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			cmd_s1.opcode     <= s_tdata[4:0];
			cmd_s1.count      <= s_tdata[16:5];
			cmd_s1.arg_col    <= s_tdata[28:17];
			cmd_s1.arg_row    <= s_tdata[40:29];
			cmd_s1.arg_bottom <= s_tdata[52:41];
			cmd_s1.char_wide  <= s_tdata[53];
		end
	end

	// Result register: hold until the consumer takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	// Terminal state and size registers. The user's writes must come only while idle, so
	// a configuration write and a command update never meet; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= RESET_COLUMNS;
			rows_q    <= RESET_ROWS;
			st_q      <= '{cur_col: 9'd0, cur_row: 8'd0, saved_col: 9'd0,
				saved_row: 8'd0, region_top: 8'd0, region_bottom: RESET_ROWS,
				alt_screen: 1'b0};
		end else if (cfg_xfer) begin
			if (cfg_index == REG_COLUMNS) begin
				columns_q <= cfg_data;
				// Pull the cursor back inside a narrower screen
				if (st_q.cur_col > cfg_dim) st_q.cur_col <= cfg_dim;
			end else if (cfg_index == REG_ROWS) begin
				rows_q <= cfg_data;
				// New height: margins back to the full screen
				st_q.region_top    <= 8'd0;
				st_q.region_bottom <= cfg_dim;
				if ({1'b0, st_q.cur_row} > cfg_dim - 9'd1) begin
					st_q.cur_row <= 8'(cfg_dim - 9'd1);
				end
			end
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, res_s2.write_wide, res_s2.write_row, res_s2.write_col,
		res_s2.write_valid, res_s2.to_scrollback, res_s2.scroll_down_lines,
		res_s2.scroll_up_lines, res_s2.margin_bottom, res_s2.margin_top,
		res_s2.cursor_row, res_s2.cursor_col};

	assign w_eff_ok = (st_q.cur_col <= w_eff);

	// Margins stay ordered and within the screen
	a_margin_order: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, st_q.region_top} <= st_q.region_bottom) && (st_q.region_bottom <= h_eff))
		else $error("scroll margins out of order or off screen");

	// Cursor column never passes the pending-wrap position
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n) w_eff_ok)
		else $error("cursor column beyond screen width");

	// Scrollback only goes with an upward scroll
	a_scrollback: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.to_scrollback) |-> (res_s2.scroll_up_lines != 9'd0))
		else $error("scrollback flagged without upward scroll");

	// A full command stage behind a stalled result must block new commands
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("command accepted while both stages are stalled");

	// Non-print results carry a cleared write cell
	a_write_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.write_valid) |->
		(res_s2.write_col == 8'd0 && res_s2.write_row == 8'd0 && !res_s2.write_wide))
		else $error("write cell set on a non-print result");

endmodule

`default_nettype wire

// ----- bench/cursor_result_checker.sv -----
module cursor_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// s_tdata, lowest bit up: opcode, count, arg_col, arg_row, arg_bottom, char_wide
	input  wire logic [55:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// m_tdata, lowest bit up: cursor_col, cursor_row, margin_top, margin_bottom,
	// scroll_up_lines, scroll_down_lines, to_scrollback, write_valid, write_col,
	// write_row, write_wide
	input  wire logic [71:0] m_tdata,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [8:0]  cfg_data,
	output int               mismatches,
	output int               outstanding,
	output int               results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import tcm_pkg::*;

	localparam int TAB_STOP = 1 << TAB_SHIFT;

	// Shadow of the block's registers and cursor state
	logic [8:0] cols_reg;
	logic [8:0] rows_reg;
	logic [8:0] cur_col;
	logic [7:0] cur_row;
	logic [8:0] saved_col;
	logic [7:0] saved_row;
	logic [7:0] region_top;
	logic [8:0] region_bottom;
	logic       alt_screen;

	res_t       pending_results[$];
	res_t       want;
	cmd_t       seen;
	int         fails;
	int         checked;

	function automatic int usable_dim(input logic [8:0] v, input logic [8:0] lim);
		if (v == 9'd0) begin
			return 1;
		end
		if (v > lim) begin
			return int'(lim);
		end
		return int'(v);
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Move up by n; returns the scroll-down amount past the top margin
	function automatic int rows_up(inout int row, input int n, input int top, input int bot);
		int next;
		int push;
		next = row - n;
		push = 0;
		if (row >= top) begin
			if (next < top) begin
				push = top - next;
				next = top;
			end
		end else if (next < 0) begin
			next = 0;
		end
		row = next;
		return clamp(push, 0, bot - top);
	endfunction

	// Move down by n; returns the scroll-up amount past the bottom margin
	function automatic int rows_down(inout int row, input int n, input int top, input int bot,
			input int h);
		int next;
		int push;
		next = row + n;
		push = 0;
		if (row < bot) begin
			if (next >= bot) begin
				push = next - (bot - 1);
				next = bot - 1;
			end
		end else if (next >= h) begin
			next = h - 1;
		end
		row = next;
		return clamp(push, 0, bot - top);
	endfunction

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
		if (idx == REG_COLUMNS) begin
			cols_reg = data;
			if (int'(cur_col) > usable_dim(cols_reg, MAX_COLS)) begin
				cur_col = 9'(usable_dim(cols_reg, MAX_COLS));
			end
		end else if (idx == REG_ROWS) begin
			rows_reg = data;
			region_top = '0;
			region_bottom = 9'(usable_dim(rows_reg, MAX_ROWS));
			if (int'(cur_row) > usable_dim(rows_reg, MAX_ROWS) - 1) begin
				cur_row = 8'(usable_dim(rows_reg, MAX_ROWS) - 1);
			end
		end
	endtask

	function automatic res_t cursor_predict(input cmd_t c);
		res_t r;
		int w, h, n, col, row, top, bot, up, down, cw, amt, stop;
		w = usable_dim(cols_reg, MAX_COLS);
		h = usable_dim(rows_reg, MAX_ROWS);
		n = int'(c.count);
		col = int'(cur_col);
		row = int'(cur_row);
		top = int'(region_top);
		bot = int'(region_bottom);
		up = 0;
		down = 0;
		r = '0;
		case (c.opcode)
			OP_UP: begin
				if (n > 0) amt = rows_up(row, n, top, bot);
			end
			OP_DOWN: begin
				if (n > 0) amt = rows_down(row, n, top, bot, h);
			end
			OP_LEFT: begin
				if (n > 0) col = clamp(col - n, 0, w);
			end
			OP_RIGHT: begin
				if (n > 0) col = clamp(col + n, 0, w - 1);
			end
			OP_INDEX: begin
				if (n > 0) up = rows_down(row, n, top, bot, h);
			end
			OP_REVINDEX: begin
				if (n > 0) down = rows_up(row, n, top, bot);
			end
			OP_MOVETO: begin
				col = clamp(int'(c.arg_col), 0, w - 1);
				row = clamp(int'(c.arg_row), 0, h - 1);
			end
			OP_TAB: begin
				if (n > 0 && col < w - 1) begin
					stop = (col / TAB_STOP + 1) * TAB_STOP + (n - 1) * TAB_STOP;
					col = clamp(stop, 0, w - 1);
				end
			end
			OP_BACKTAB: begin
				if (n > 0 && col > 0) begin
					stop = ((col - 1) / TAB_STOP) * TAB_STOP - (n - 1) * TAB_STOP;
					col = clamp(stop, 0, w);
				end
			end
			OP_BS: begin
				if (col > 0) col = col - 1;
			end
			OP_REGION: begin
				// a bottom above the top leaves everything alone
				if (c.arg_bottom >= c.arg_row) begin
					top = clamp(int'(c.arg_row), 0, h - 1);
					bot = clamp(int'(c.arg_bottom), 0, h);
					col = 0;
					row = 0;
				end
			end
			OP_SAVE: begin
				saved_col = 9'(col);
				saved_row = 8'(row);
			end
			OP_RESTORE: begin
				col = clamp(int'(saved_col), 0, w - 1);
				row = clamp(int'(saved_row), 0, h - 1);
			end
			OP_PRINT: begin
				cw = (c.char_wide && w >= 2) ? 2 : 1;
				if (col + cw > w) begin
					up = rows_down(row, 1, top, bot, h);
					col = 0;
				end
				r.write_valid = 1'b1;
				r.write_col = 8'(col);
				r.write_row = 8'(row);
				r.write_wide = (cw == 2);
				col = col + cw;
			end
			OP_SCROLLUP: begin
				if (n > 0) begin
					up = clamp(n, 0, bot - top);
					if (row >= top && row < bot) begin
						amt = clamp(n, 0, row - top);
						col = clamp(col, 0, w - 1);
						row = clamp(row - amt, 0, h - 1);
					end
				end
			end
			OP_SCROLLDOWN: begin
				if (n > 0) begin
					down = clamp(n, 0, bot - top);
					if (row >= top && row < bot) begin
						amt = clamp(n, 0, bot - 1 - row);
						col = clamp(col, 0, w - 1);
						row = clamp(row + amt, 0, h - 1);
					end
				end
			end
			OP_SCREEN: begin
				alt_screen = c.arg_col[0];
			end
			default: begin
			end
		endcase
		cur_col = 9'(col);
		cur_row = 8'(row);
		region_top = 8'(top);
		region_bottom = 9'(bot);
		r.cursor_col = 9'(col);
		r.cursor_row = 8'(row);
		r.margin_top = 8'(top);
		r.margin_bottom = 9'(bot);
		r.scroll_up_lines = 9'(up);
		r.scroll_down_lines = 9'(down);
		r.to_scrollback = (up > 0 && top == 0 && !alt_screen);
		return r;
	endfunction

	task automatic report(input string msg);
		fails++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int exp_val);
		if (got != exp_val) begin
			report($sformatf("result %0d %s got %0d expected %0d", checked, name, got, exp_val));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg = RESET_COLUMNS;
			rows_reg = RESET_ROWS;
			cur_col = '0;
			cur_row = '0;
			saved_col = '0;
			saved_row = '0;
			region_top = '0;
			region_bottom = 9'(usable_dim(RESET_ROWS, MAX_ROWS));
			alt_screen = 1'b0;
			pending_results.delete();
			fails = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
			end
			// compare before queueing, so a result can never meet its own command
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", checked));
				end else begin
					want = pending_results.pop_front();
					check_field("cursor_col", int'(m_tdata[8:0]), int'(want.cursor_col));
					check_field("cursor_row", int'(m_tdata[16:9]), int'(want.cursor_row));
					check_field("margin_top", int'(m_tdata[24:17]), int'(want.margin_top));
					check_field("margin_bottom", int'(m_tdata[33:25]),
						int'(want.margin_bottom));
					check_field("scroll_up_lines", int'(m_tdata[42:34]),
						int'(want.scroll_up_lines));
					check_field("scroll_down_lines", int'(m_tdata[51:43]),
						int'(want.scroll_down_lines));
					check_field("to_scrollback", int'(m_tdata[52]),
						int'(want.to_scrollback));
					check_field("write_valid", int'(m_tdata[53]), int'(want.write_valid));
					check_field("write_col", int'(m_tdata[61:54]), int'(want.write_col));
					check_field("write_row", int'(m_tdata[69:62]), int'(want.write_row));
					check_field("write_wide", int'(m_tdata[70]), int'(want.write_wide));
				end
				checked++;
			end
			if (s_tvalid && s_tready) begin
				seen.opcode = s_tdata[4:0];
				seen.count = s_tdata[16:5];
				seen.arg_col = s_tdata[28:17];
				seen.arg_row = s_tdata[40:29];
				seen.arg_bottom = s_tdata[52:41];
				seen.char_wide = s_tdata[53];
				pending_results.push_back(cursor_predict(seen));
			end
		end
		mismatches <= fails;
		outstanding <= pending_results.size();
		results_checked <= checked;
	end

endmodule

// ----- bench/terminal_cursor_margin_controller_top_tb.sv -----
module terminal_cursor_margin_controller_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcm_pkg::*;

	// Random part: one phase per screen size, 115 commands each
	localparam int NUM_SIZES      = 8;
	localparam int ITEMS_PER_SIZE = 115;
	// Opcodes past the last defined command; the block must ignore them
	localparam logic [4:0] OP_FIRST_UNUSED = 5'd17;
	localparam logic [4:0] OP_LAST_UNUSED  = 5'd31;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_COLUMNS;
	logic [8:0]  cfg_data = '0;

	int          mismatches;
	int          outstanding;
	int          results_checked;

	// Idle odds in percent per cycle for the command and result sides
	int          send_gap_pct = 0;
	int          hold_pct = 0;
	// Screen size currently programmed, used only to aim the random arguments
	int          shape_w = int'(RESET_COLUMNS);
	int          shape_h = int'(RESET_ROWS);
	int          sent = 0;

	terminal_cursor_margin_controller_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cursor_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result side at the odds of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= hold_pct);
	end

	// Hard stop; a correct run finishes in a small fraction of this
	initial begin
		#2ms;
		$display("run exceeded its time limit, %0d results still outstanding", outstanding);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic cmd_t mk(input logic [4:0] op, input int cnt, input int col,
			input int row, input int bot, input logic wide);
		cmd_t c;
		c.opcode = op;
		c.count = cnt[11:0];
		c.arg_col = col[11:0];
		c.arg_row = row[11:0];
		c.arg_bottom = bot[11:0];
		c.char_wide = wide;
		return c;
	endfunction

	function automatic int usable(input logic [8:0] v);
		if (v == 9'd0) begin
			return 1;
		end
		return int'((v > MAX_COLS) ? MAX_COLS : v);
	endfunction

	// Mostly inside the screen, some right at its edge, a few anywhere in 12 bits
	function automatic int near_edge(input int lim);
		int r;
		r = $urandom_range(99);
		if (r < 70) begin
			return $urandom_range(lim);
		end
		if (r < 88) begin
			return lim - 1 + $urandom_range(2);
		end
		return $urandom_range(4095);
	endfunction

	// Small repeat counts dominate; zero and the full range show up too
	function automatic int pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 8) begin
			return 0;
		end
		if (r < 70) begin
			return $urandom_range(4, 1);
		end
		if (r < 88) begin
			return $urandom_range(shape_h + 2, 1);
		end
		return $urandom_range(4095);
	endfunction

	// Weighted toward print runs and line feeds so wraps and region scrolls happen
	// often; unused fields carry random bits
	function automatic cmd_t random_cmd();
		cmd_t c;
		int r;
		int top;
		c = mk(OP_PRINT, $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(99) < 40);
		r = $urandom_range(99);
		if (r < 30 || r >= 88) begin
			c.opcode = OP_PRINT;
		end else if (r < 36) begin
			case ($urandom_range(3))
				0: c.opcode = OP_UP;
				1: c.opcode = OP_DOWN;
				2: c.opcode = OP_LEFT;
				default: c.opcode = OP_RIGHT;
			endcase
			c.count = 12'(pick_count());
		end else if (r < 46) begin
			c.opcode = $urandom_range(1) ? OP_INDEX : OP_REVINDEX;
			c.count = 12'(pick_count());
		end else if (r < 54) begin
			case ($urandom_range(2))
				0: c.opcode = OP_TAB;
				1: c.opcode = OP_BACKTAB;
				default: c.opcode = OP_BS;
			endcase
			c.count = 12'(pick_count());
		end else if (r < 62) begin
			c.opcode = OP_MOVETO;
			c.arg_col = 12'(near_edge(shape_w));
			c.arg_row = 12'(near_edge(shape_h));
		end else if (r < 68) begin
			c.opcode = OP_REGION;
			top = near_edge(shape_h);
			c.arg_row = 12'(top);
			// mostly a valid region; sometimes a bottom above the top
			if ($urandom_range(99) < 85 || top == 0) begin
				c.arg_bottom = 12'($urandom_range(shape_h + 1 > top ? shape_h + 1 : top, top));
			end else begin
				c.arg_bottom = 12'($urandom_range(top - 1));
			end
		end else if (r < 74) begin
			c.opcode = $urandom_range(1) ? OP_SAVE : OP_RESTORE;
		end else if (r < 82) begin
			c.opcode = $urandom_range(1) ? OP_SCROLLUP : OP_SCROLLDOWN;
			c.count = 12'(pick_count());
		end else if (r < 85) begin
			c.opcode = OP_SCREEN;
		end else begin
			c.opcode = 5'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
		end
		return c;
	endfunction

	// Offer one command, idling first at the phase's odds; return on the transfer
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, c.char_wide, c.arg_bottom, c.arg_row, c.arg_col, c.count,
			c.opcode};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// Hold off commands until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [8:0] new_cols;
		logic [8:0] new_rows;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed pass on the reset screen, 80 by 24
		send_cmd(mk(OP_PRINT, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_PRINT, 0, 0, 0, 0, 1'b1));
		// wide character with one cell left: line feed at the bottom, scroll to history
		send_cmd(mk(OP_MOVETO, 0, 79, 23, 0, 1'b0));
		send_cmd(mk(OP_PRINT, 0, 0, 0, 0, 1'b1));
		// narrow print into the last column leaves a wrap pending
		send_cmd(mk(OP_MOVETO, 0, 79, 23, 0, 1'b0));
		send_cmd(mk(OP_PRINT, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_TAB, 1, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_BACKTAB, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_RIGHT, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_PRINT, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_PRINT, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_LEFT, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_UP, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_UP, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_INDEX, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_REVINDEX, 4095, 0, 0, 0, 1'b0));
		// region, then an inverted one, then one far past the screen
		send_cmd(mk(OP_REGION, 0, 0, 5, 10, 1'b0));
		send_cmd(mk(OP_SAVE, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_DOWN, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_REGION, 0, 0, 9, 3, 1'b0));
		send_cmd(mk(OP_SCREEN, 0, 1, 0, 0, 1'b0));
		send_cmd(mk(OP_SCROLLUP, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_REGION, 0, 0, 4095, 4095, 1'b0));
		send_cmd(mk(OP_SCREEN, 0, 4094, 0, 0, 1'b0));
		send_cmd(mk(OP_MOVETO, 0, 4095, 4095, 0, 1'b0));
		send_cmd(mk(OP_RESTORE, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_SCROLLDOWN, 4095, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_BS, 0, 0, 0, 0, 1'b0));
		send_cmd(mk(OP_LAST_UNUSED, 4095, 4095, 4095, 4095, 1'b1));
		drain();

		// Random phases over several screen sizes, extremes included
		for (int p = 0; p < NUM_SIZES; p++) begin
			case (p)
				0: begin new_cols = 9'd1;   new_rows = 9'd1;   end
				1: begin new_cols = 9'd256; new_rows = 9'd256; end
				2: begin new_cols = 9'd0;   new_rows = 9'd0;   end
				3: begin new_cols = 9'd511; new_rows = 9'd300; end
				4: begin new_cols = 9'd2;   new_rows = 9'd3;   end
				5: begin new_cols = 9'd132; new_rows = 9'd50;  end
				6: begin
					new_cols = 9'($urandom_range(256, 1));
					new_rows = 9'($urandom_range(256, 1));
				end
				default: begin new_cols = RESET_COLUMNS; new_rows = RESET_ROWS; end
			endcase
			// odds: sender light and receiver heavy, then swapped, then none
			send_gap_pct = (p < 3) ? 17 : (p < 6) ? 70 : 0;
			hold_pct = (p < 3) ? 70 : (p < 6) ? 17 : 0;
			if ($urandom_range(1)) begin
				write_reg(REG_COLUMNS, new_cols);
				write_reg(REG_ROWS, new_rows);
			end else begin
				write_reg(REG_ROWS, new_rows);
				write_reg(REG_COLUMNS, new_cols);
			end
			shape_w = usable(new_cols);
			shape_h = usable(new_rows);
			for (int i = 0; i < ITEMS_PER_SIZE; i++) begin
				if (p == 1 && i == 40) begin
					drain();
				end
				send_cmd(random_cmd());
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("%0d commands over %0d screen sizes, %0d results compared",
			sent, NUM_SIZES + 1, results_checked);
		$display("%0d mismatches, %0d results outstanding", mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
